// ===== design/psq_pkg.sv =====
// shared constants, types and codes of the priority semaphore wait queue
package psq_pkg;

    localparam int QUEUE_DEPTH    = 8;
    localparam int TASK_ID_WIDTH  = 4;
    localparam int PRIORITY_WIDTH = 4;

    localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int MAX_W    = 8;
    localparam int COUNT_W  = 9;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [MAX_W-1:0]   MAX_RESET = MAX_W'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOCK     = 3'd0,
        CMD_UNLOCK   = 3'd1,
        CMD_WAIT     = 3'd2,
        CMD_SIG_ONE  = 3'd3,
        CMD_SIG_ALL  = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctl_t;

    typedef struct packed {
        logic last;
    } sts_t;

endpackage

// ===== design/psq_queue.sv =====
// priority-sorted wait queue cells with stable insertion and head removal
module psq_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic                                pop,
    input  logic [psq_pkg::TASK_ID_WIDTH-1:0]   push_id,
    input  logic [psq_pkg::PRIORITY_WIDTH-1:0]  push_prio,
    output logic [psq_pkg::TASK_ID_WIDTH-1:0]   head_id,
    output logic [psq_pkg::FILL_W-1:0]          fill
);
    import psq_pkg::*;

    logic [TASK_ID_WIDTH-1:0]  ids_reg   [QUEUE_DEPTH];
    logic [PRIORITY_WIDTH-1:0] prios_reg [QUEUE_DEPTH];
    logic [TASK_ID_WIDTH-1:0]  ids_next  [QUEUE_DEPTH];
    logic [PRIORITY_WIDTH-1:0] prios_next[QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]    keep;
    logic [FILL_W-1:0]         fill_reg;
    logic [FILL_W-1:0]         fill_next;

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
            // cell keeps its entry when it is occupied and not outranked
            assign keep[i] = (FILL_W'(i) < fill_reg) && (prios_reg[i] >= push_prio);

            always_comb
            begin
                ids_next[i]   = ids_reg[i];
                prios_next[i] = prios_reg[i];
                if (push)
                begin
                    if (!keep[i])
                    begin
                        if (i == 0)
                        begin
                            ids_next[i]   = push_id;
                            prios_next[i] = push_prio;
                        end
                        else if (keep[(i == 0) ? 0 : i - 1])
                        begin
                            ids_next[i]   = push_id;
                            prios_next[i] = push_prio;
                        end
                        else
                        begin
                            ids_next[i]   = ids_reg[(i == 0) ? 0 : i - 1];
                            prios_next[i] = prios_reg[(i == 0) ? 0 : i - 1];
                        end
                    end
                end
                else if (pop && (i < QUEUE_DEPTH - 1))
                begin
                    ids_next[i]   = ids_reg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                    prios_next[i] = prios_reg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (push || pop)
                begin
                    ids_reg[i]   <= ids_next[i];
                    prios_reg[i] <= prios_next[i];
                end
            end
        end
    endgenerate

    always_comb
    begin
        fill_next = fill_reg;
        if (push)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (pop)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    assign head_id = ids_reg[0];
    assign fill    = fill_reg;

endmodule

// ===== design/psq_datapath.sv =====
// command registers, semaphore count, wait queue and result register
module psq_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  psq_pkg::ctl_t                       ctl,
    output psq_pkg::sts_t                       sts,
    input  logic                                cfg_write,
    input  logic [psq_pkg::MAX_W-1:0]           cfg_data,
    input  logic [psq_pkg::CMD_W-1:0]           command,
    input  logic [psq_pkg::TASK_ID_WIDTH-1:0]   task_id,
    input  logic [psq_pkg::PRIORITY_WIDTH-1:0]  task_priority,
    output logic [psq_pkg::TASK_ID_WIDTH-1:0]   woken_task,
    output logic                                woke,
    output logic                                must_block,
    output logic [psq_pkg::STATUS_W-1:0]        status,
    output logic [psq_pkg::FILL_W-1:0]          waiters,
    output logic [psq_pkg::COUNT_W-1:0]         count_value,
    output logic                                last
);
    import psq_pkg::*;

    logic [CMD_W-1:0]          cmd_reg;
    logic [TASK_ID_WIDTH-1:0]  id_reg;
    logic [PRIORITY_WIDTH-1:0] prio_reg;
    logic [MAX_W-1:0]          max_value_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;
    logic [COUNT_W-1:0]        count_inc;

    logic [TASK_ID_WIDTH-1:0]  woken_reg;
    logic                      woke_reg;
    logic                      block_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic [FILL_W-1:0]         waiters_reg;
    logic [COUNT_W-1:0]        count_out_reg;
    logic                      last_reg;

    logic                      push;
    logic                      pop;
    logic                      woke_c;
    logic                      block_c;
    status_t                   status_c;
    logic                      last_c;
    logic [TASK_ID_WIDTH-1:0]  head_id;
    logic [FILL_W-1:0]         fill;
    logic [FILL_W-1:0]         fill_after;
    logic                      full;
    logic                      empty;
    logic                      over;

    psq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push && ctl.exec),
        .pop       (pop && ctl.exec),
        .push_id   (id_reg),
        .push_prio (prio_reg),
        .head_id   (head_id),
        .fill      (fill)
    );

    assign full      = (fill == FILL_W'(QUEUE_DEPTH));
    assign empty     = (fill == '0);
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);
    assign over      = (count_inc > COUNT_W'(max_value_reg));

    always_comb
    begin
        push       = 1'b0;
        pop        = 1'b0;
        count_next = count_reg;
        woke_c     = 1'b0;
        block_c    = 1'b0;
        status_c   = ST_OK;
        last_c     = 1'b1;
        unique case (cmd_t'(cmd_reg))
            CMD_LOCK:
            begin
                if (over)
                begin
                    if (!full)
                    begin
                        push       = 1'b1;
                        count_next = count_inc;
                        block_c    = 1'b1;
                    end
                    else
                    begin
                        status_c = ST_FULL;
                    end
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            CMD_UNLOCK:
            begin
                if (count_reg == '0)
                begin
                    status_c = ST_UNDERFLOW;
                end
                else
                begin
                    count_next = count_reg - COUNT_W'(1);
                end
                pop    = !empty;
                woke_c = !empty;
            end
            CMD_WAIT:
            begin
                if (!full)
                begin
                    push    = 1'b1;
                    block_c = 1'b1;
                end
                else
                begin
                    status_c = ST_FULL;
                end
            end
            CMD_SIG_ONE:
            begin
                pop    = !empty;
                woke_c = !empty;
            end
            CMD_SIG_ALL:
            begin
                pop    = !empty;
                woke_c = !empty;
                last_c = (fill == '0) || (fill == FILL_W'(1));
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        fill_after = fill;
        if (push)
        begin
            fill_after = fill + FILL_W'(1);
        end
        else if (pop)
        begin
            fill_after = fill - FILL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= command;
            id_reg   <= task_id;
            prio_reg <= task_priority;
        end
        if (ctl.exec)
        begin
            woken_reg     <= woke_c ? head_id : '0;
            woke_reg      <= woke_c;
            block_reg     <= block_c;
            status_reg    <= status_c;
            waiters_reg   <= fill_after;
            count_out_reg <= count_next;
            last_reg      <= last_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            max_value_reg <= MAX_RESET;
        end
        else
        begin
            if (ctl.exec)
            begin
                count_reg <= count_next;
            end
            if (cfg_write)
            begin
                max_value_reg <= cfg_data;
            end
        end
    end

    assign sts.last    = last_c;
    assign woken_task  = woken_reg;
    assign woke        = woke_reg;
    assign must_block  = block_reg;
    assign status      = status_reg;
    assign waiters     = waiters_reg;
    assign count_value = count_out_reg;
    assign last        = last_reg;

endmodule

// ===== design/psq_ctrl.sv =====
// controller: input handshake, execute sequencing and result valid
module psq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output psq_pkg::ctl_t  ctl,
    input  psq_pkg::sts_t  sts
);
    import psq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free && sts.last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        ctl      = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                ctl.load = in_valid;
            end
            S_EXEC:
            begin
                ctl.exec = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== design/priority_semaphore_wait_queue_core.sv =====
// top level of the counting semaphore with priority-ordered wait queue
// A command is first accepted, which loads the command registers, and then the controller's single execute
// step updates the count and the sorted wait queue and loads the result register.
// Signal all repeats the execute step once per released waiter, giving one result per cycle
// while out_ready stays high. The result register separates the two channels: the next
// command is accepted while a result still waits; the execute step stalls only while the
// result register is full and not taken.
module priority_semaphore_wait_queue_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [psq_pkg::MAX_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [psq_pkg::CMD_W-1:0]           command,
    input  logic [psq_pkg::TASK_ID_WIDTH-1:0]   task_id,
    input  logic [psq_pkg::PRIORITY_WIDTH-1:0]  task_priority,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [psq_pkg::TASK_ID_WIDTH-1:0]   woken_task,
    output logic                                woke,
    output logic                                must_block,
    output logic [psq_pkg::STATUS_W-1:0]        status,
    output logic [psq_pkg::FILL_W-1:0]          waiters,
    output logic [psq_pkg::COUNT_W-1:0]         count_value,
    output logic                                last
);
    import psq_pkg::*;

    ctl_t ctl;
    sts_t sts;

    psq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl),
        .sts       (sts)
    );

    psq_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .command       (command),
        .task_id       (task_id),
        .task_priority (task_priority),
        .woken_task    (woken_task),
        .woke          (woke),
        .must_block    (must_block),
        .status        (status),
        .waiters       (waiters),
        .count_value   (count_value),
        .last          (last)
    );

endmodule

// ===== design/psq_checker.sv =====
// port-level assertions for the semaphore core and their bind
module psq_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [psq_pkg::TASK_ID_WIDTH-1:0]   woken_task,
    input  logic                                woke,
    input  logic                                must_block,
    input  logic [psq_pkg::STATUS_W-1:0]        status,
    input  logic [psq_pkg::FILL_W-1:0]          waiters,
    input  logic [psq_pkg::COUNT_W-1:0]         count_value,
    input  logic                                last
);
    import psq_pkg::*;

    // held result transaction keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(woken_task) && $stable(last)
            && $stable(count_value))
        else $error("result changed while stalled");

    // one command in flight at a time
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after accept");

    a_no_wake_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !woke |-> woken_task == '0)
        else $error("woken task set without wake");

    a_block_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && must_block |-> !woke && status == ST_OK && last)
        else $error("blocking result inconsistent");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> waiters <= FILL_W'(QUEUE_DEPTH))
        else $error("waiter count above queue depth");

endmodule

bind priority_semaphore_wait_queue_core psq_checker u_psq_checker (.*);

// ===== dv/priority_semaphore_wait_queue_core_tb.sv =====
// self-checking testbench for the priority semaphore wait queue core
module priority_semaphore_wait_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psq_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_C = 3'd7;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 200;
    localparam int SETTLE_TAIL  = 20;

    typedef struct {
        logic [CMD_W-1:0]          cmd;
        logic [TASK_ID_WIDTH-1:0]  id;
        logic [PRIORITY_WIDTH-1:0] prio;
    } sem_cmd_t;

    typedef struct {
        logic [TASK_ID_WIDTH-1:0] woken;
        logic                     woke;
        logic                     blk;
        status_t                  st;
        logic [FILL_W-1:0]        fill;
        logic [COUNT_W-1:0]       cnt;
        logic                     last;
    } sem_reply_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write = 1'b0;
    logic [MAX_W-1:0]          cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [CMD_W-1:0]          command = '0;
    logic [TASK_ID_WIDTH-1:0]  task_id = '0;
    logic [PRIORITY_WIDTH-1:0] task_priority = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [TASK_ID_WIDTH-1:0]  woken_task;
    logic                      woke;
    logic                      must_block;
    logic [STATUS_W-1:0]       status;
    logic [FILL_W-1:0]         waiters;
    logic [COUNT_W-1:0]        count_value;
    logic                      last;

    // predictor state
    logic [TASK_ID_WIDTH-1:0]  wq_id [QUEUE_DEPTH];
    logic [PRIORITY_WIDTH-1:0] wq_prio [QUEUE_DEPTH];
    int                        wq_fill = 0;
    logic [COUNT_W-1:0]        sem_cnt = '0;
    logic [MAX_W-1:0]          sem_max = MAX_RESET;

    sem_cmd_t   command_backlog [$];
    sem_reply_t predicted_replies [$];
    int         cmds_queued = 0;
    int         cmds_taken = 0;
    int         err_count = 0;
    int         send_gap_pct = 0;
    int         stall_pct = 0;
    logic       hold_request = 1'b0;
    int         quiet_cycles = 0;

    priority_semaphore_wait_queue_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .task_id       (task_id),
        .task_priority (task_priority),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .woken_task    (woken_task),
        .woke          (woke),
        .must_block    (must_block),
        .status        (status),
        .waiters       (waiters),
        .count_value   (count_value),
        .last          (last)
    );

    always #5 clk = ~clk;

    function automatic bit wq_push(logic [TASK_ID_WIDTH-1:0] id,
                                   logic [PRIORITY_WIDTH-1:0] prio);
        if (wq_fill >= QUEUE_DEPTH)
            return 1'b0;
        wq_id[wq_fill] = id;
        wq_prio[wq_fill] = prio;
        wq_fill++;
        return 1'b1;
    endfunction

    // highest priority first, earliest among equals
    function automatic bit wq_pop(output logic [TASK_ID_WIDTH-1:0] id);
        int best;
        best = 0;
        id = '0;
        if (wq_fill == 0)
            return 1'b0;
        for (int i = 1; i < wq_fill; i++)
            if (wq_prio[i] > wq_prio[best])
                best = i;
        id = wq_id[best];
        for (int i = best; i + 1 < wq_fill; i++)
        begin
            wq_id[i] = wq_id[i + 1];
            wq_prio[i] = wq_prio[i + 1];
        end
        wq_fill--;
        return 1'b1;
    endfunction

    function automatic void post_reply(logic [TASK_ID_WIDTH-1:0] id, logic woke_b,
                                       logic blk, status_t st, logic lst);
        sem_reply_t r;
        r.woken = id;
        r.woke = woke_b;
        r.blk = blk;
        r.st = st;
        r.fill = FILL_W'(wq_fill);
        r.cnt = sem_cnt;
        r.last = lst;
        predicted_replies.push_back(r);
    endfunction

    function automatic void apply_command(logic [CMD_W-1:0] cmd,
                                          logic [TASK_ID_WIDTH-1:0] id,
                                          logic [PRIORITY_WIDTH-1:0] prio);
        logic [COUNT_W-1:0]       next_cnt;
        logic [TASK_ID_WIDTH-1:0] wid;
        bit                       got;
        status_t                  st;
        case (cmd)
            CMD_LOCK:
            begin
                next_cnt = (sem_cnt < COUNT_MAX) ? sem_cnt + 1'b1 : COUNT_MAX;
                if (next_cnt > {1'b0, sem_max})
                begin
                    if (wq_push(id, prio))
                    begin
                        sem_cnt = next_cnt;
                        post_reply('0, 1'b0, 1'b1, ST_OK, 1'b1);
                    end
                    else
                        post_reply('0, 1'b0, 1'b0, ST_FULL, 1'b1);
                end
                else
                begin
                    sem_cnt = next_cnt;
                    post_reply('0, 1'b0, 1'b0, ST_OK, 1'b1);
                end
            end
            CMD_UNLOCK:
            begin
                st = ST_OK;
                if (sem_cnt == 0)
                    st = ST_UNDERFLOW;
                else
                    sem_cnt = sem_cnt - 1'b1;
                got = wq_pop(wid);
                post_reply(got ? wid : '0, got, 1'b0, st, 1'b1);
            end
            CMD_WAIT:
            begin
                if (wq_push(id, prio))
                    post_reply('0, 1'b0, 1'b1, ST_OK, 1'b1);
                else
                    post_reply('0, 1'b0, 1'b0, ST_FULL, 1'b1);
            end
            CMD_SIG_ONE:
            begin
                got = wq_pop(wid);
                post_reply(got ? wid : '0, got, 1'b0, ST_OK, 1'b1);
            end
            CMD_SIG_ALL:
            begin
                if (wq_fill == 0)
                    post_reply('0, 1'b0, 1'b0, ST_OK, 1'b1);
                else
                    while (wq_pop(wid))
                        post_reply(wid, 1'b1, 1'b0, ST_OK, wq_fill == 0);
            end
            default:
                post_reply('0, 1'b0, 1'b0, ST_OK, 1'b1);
        endcase
    endfunction

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        $display("mismatch at %0t on %s: got %0d, expected %0d", $realtime, field, got, want);
        err_count++;
    endtask

    task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic [TASK_ID_WIDTH-1:0] id,
                             logic [PRIORITY_WIDTH-1:0] prio);
        sem_cmd_t c;
        c.cmd = cmd;
        c.id = id;
        c.prio = prio;
        command_backlog.push_back(c);
        cmds_queued++;
    endtask

    // mostly groups of blocking commands followed by releases, plus single commands
    task automatic queue_random(int n);
        int made;
        int burst;
        int roll;
        made = 0;
        while (made < n)
        begin
            roll = $urandom_range(99);
            if (roll < 55)
            begin
                burst = $urandom_range(10, 1);
                for (int k = 0; k < burst; k++)
                    queue_cmd($urandom_range(1) ? CMD_LOCK : CMD_WAIT,
                              TASK_ID_WIDTH'($urandom_range(15)),
                              PRIORITY_WIDTH'($urandom_range(15)));
                made += burst;
                case ($urandom_range(2))
                    0:
                    begin
                        queue_cmd(CMD_SIG_ALL, TASK_ID_WIDTH'($urandom_range(15)),
                                  PRIORITY_WIDTH'($urandom_range(15)));
                        made++;
                    end
                    1:
                    begin
                        for (int k = 0; k < burst; k++)
                            queue_cmd(CMD_UNLOCK, TASK_ID_WIDTH'($urandom_range(15)),
                                      PRIORITY_WIDTH'($urandom_range(15)));
                        made += burst;
                    end
                    default:
                    begin
                        roll = $urandom_range(burst, 1);
                        for (int k = 0; k < roll; k++)
                            queue_cmd(CMD_SIG_ONE, TASK_ID_WIDTH'($urandom_range(15)),
                                      PRIORITY_WIDTH'($urandom_range(15)));
                        made += roll;
                    end
                endcase
            end
            else if (roll < 95)
            begin
                queue_cmd(CMD_W'($urandom_range(CMD_SIG_ALL, CMD_LOCK)),
                          TASK_ID_WIDTH'($urandom_range(15)),
                          PRIORITY_WIDTH'($urandom_range(15)));
                made++;
            end
            else
            begin
                queue_cmd(CMD_W'($urandom_range(CMD_UNUSED_C, CMD_UNUSED_A)),
                          TASK_ID_WIDTH'($urandom_range(15)),
                          PRIORITY_WIDTH'($urandom_range(15)));
                made++;
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (cmds_taken != cmds_queued || predicted_replies.size() != 0);
    endtask

    task automatic set_max_value(logic [MAX_W-1:0] v);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        sem_max = v;
    endtask

    task automatic run_phase(logic [MAX_W-1:0] max_v, int send_pct, int recv_pct, int n);
        set_max_value(max_v);
        send_gap_pct = send_pct;
        stall_pct = recv_pct;
        queue_random(n);
        wait_drained();
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin : drive_commands
        bit       slot_free;
        sem_cmd_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command <= '0;
            task_id <= '0;
            task_priority <= '0;
        end
        else
        begin
            slot_free = !in_valid;
            if (in_valid && in_ready)
            begin
                apply_command(command, task_id, task_priority);
                cmds_taken++;
                slot_free = 1'b1;
            end
            if (slot_free)
            begin
                if (command_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    nxt = command_backlog.pop_front();
                    in_valid <= 1'b1;
                    command <= nxt.cmd;
                    task_id <= nxt.id;
                    task_priority <= nxt.prio;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // reply monitor
    always @(posedge clk or negedge rst_n)
    begin : check_replies
        sem_reply_t want;
        int         hold_cnt;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_cnt = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_replies.size() == 0)
                    report_mismatch("transaction with nothing predicted", 1, 0);
                else
                begin
                    want = predicted_replies.pop_front();
                    if (woken_task !== want.woken)
                        report_mismatch("woken_task", woken_task, want.woken);
                    if (woke !== want.woke)
                        report_mismatch("woke", woke, want.woke);
                    if (must_block !== want.blk)
                        report_mismatch("must_block", must_block, want.blk);
                    if (status !== want.st)
                        report_mismatch("status", status, want.st);
                    if (waiters !== want.fill)
                        report_mismatch("waiters", waiters, want.fill);
                    if (count_value !== want.cnt)
                        report_mismatch("count_value", count_value, want.cnt);
                    if (last !== want.last)
                        report_mismatch("last", last, want.last);
                end
            end
            if (hold_request && hold_cnt < HOLD_CYCLES)
            begin
                hold_cnt++;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // empty queue, zero count, unused codes
        queue_cmd(CMD_UNLOCK, 4'd0, 4'd0);
        queue_cmd(CMD_SIG_ONE, 4'd0, 4'd0);
        queue_cmd(CMD_SIG_ALL, 4'd15, 4'd15);
        queue_cmd(CMD_UNUSED_A, 4'd15, 4'd15);
        queue_cmd(CMD_UNUSED_B, 4'd10, 4'd5);
        queue_cmd(CMD_UNUSED_C, 4'd5, 4'd10);
        // fill the queue, equal priorities included, then overflow it
        queue_cmd(CMD_LOCK, 4'd0, 4'd0);
        queue_cmd(CMD_LOCK, 4'd15, 4'd15);
        queue_cmd(CMD_LOCK, 4'd5, 4'd15);
        queue_cmd(CMD_WAIT, 4'd10, 4'd0);
        queue_cmd(CMD_WAIT, 4'd3, 4'd7);
        queue_cmd(CMD_WAIT, 4'd12, 4'd7);
        queue_cmd(CMD_WAIT, 4'd9, 4'd15);
        queue_cmd(CMD_WAIT, 4'd1, 4'd3);
        queue_cmd(CMD_WAIT, 4'd2, 4'd3);
        queue_cmd(CMD_WAIT, 4'd4, 4'd1);
        queue_cmd(CMD_LOCK, 4'd6, 4'd2);
        // releases
        queue_cmd(CMD_SIG_ONE, 4'd0, 4'd0);
        queue_cmd(CMD_UNLOCK, 4'd0, 4'd0);
        queue_cmd(CMD_SIG_ALL, 4'd0, 4'd0);
        queue_cmd(CMD_UNLOCK, 4'd0, 4'd0);
        queue_cmd(CMD_UNLOCK, 4'd0, 4'd0);
        queue_cmd(CMD_UNLOCK, 4'd0, 4'd0);
        queue_random(40);
        wait_drained();

        run_phase(8'd0, 62, 0, 55);
        // long receiver hold-off while commands keep coming
        hold_request <= 1'b1;
        run_phase(8'd255, 0, 62, 50);
        run_phase(8'd3, 38, 38, 50);
        run_phase(8'd2, 0, 0, 45);

        repeat (SETTLE_TAIL) @(posedge clk);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
